[rtl/core/rtphd_pkg.sv]
package rtphd_pkg;

   localparam int POS_W = 16;
   localparam int START_W = 17;

   localparam logic [POS_W-1:0] MAX_PACKET_BYTES = 16'hFFFF;
   localparam logic [POS_W-1:0] HDR_BYTES = 16'd12;
   localparam logic [POS_W-1:0] WORD_BYTES = 16'd4;
   localparam logic [START_W-1:0] START_MAX = 17'h1FFFF;

   localparam logic [15:0] PAYLOAD_CAPACITY_RESET = 16'd1024;
   localparam logic [15:0] EXT_DATA_CAPACITY_RESET = 16'd64;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAYLOAD_CAPACITY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXT_DATA_CAPACITY = 2'd1;

   localparam logic [2:0] KIND_FIXED = 3'd0;
   localparam logic [2:0] KIND_CSRC = 3'd1;
   localparam logic [2:0] KIND_EXT_HDR = 3'd2;
   localparam logic [2:0] KIND_EXT_DATA = 3'd3;
   localparam logic [2:0] KIND_EXT_SKIP = 3'd4;
   localparam logic [2:0] KIND_PAYLOAD = 3'd5;

   localparam logic [2:0] STATUS_OK = 3'd0;
   localparam logic [2:0] STATUS_TOO_SHORT = 3'd1;
   localparam logic [2:0] STATUS_BAD_VERSION = 3'd2;
   localparam logic [2:0] STATUS_CSRC_CUT = 3'd3;
   localparam logic [2:0] STATUS_EXT_HDR_CUT = 3'd4;
   localparam logic [2:0] STATUS_EXT_DATA_CUT = 3'd5;

   localparam logic [1:0] HDR_VERSION = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic [2:0]  byte_kind;
      logic        packet_done;
      logic [2:0]  status;
      logic        marker;
      logic [6:0]  pt_value;
      logic [15:0] sequence_value;
      logic [31:0] timestamp_value;
      logic [31:0] source_id;
      logic [3:0]  contributor_count;
      logic        has_extension;
      logic [15:0] payload_bytes;
   } rsp_type;

   typedef struct packed {
      logic [15:0] payload_capacity;
      logic [15:0] ext_data_capacity;
   } cfg_type;

endpackage

[rtl/core/rtphd_parse.sv]
module rtphd_parse
   import rtphd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type result
);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [7:0]         first_ff, first_in;
   logic [7:0]         second_ff, second_in;
   logic [15:0]        seq_ff, seq_in;
   logic [31:0]        ts_ff, ts_in;
   logic [31:0]        src_ff, src_in;
   logic [15:0]        extw_ff, extw_in;
   logic [START_W-1:0] pstart_ff, pstart_in;

   logic [7:0]         b;
   logic [3:0]         cc;
   logic               xbit;
   logic [6:0]         csrc_end;
   logic [POS_W-1:0]   csrc_end16;
   logic [POS_W-1:0]   ext_data_start;
   logic               in_ext_hdr;
   logic [18:0]        ps_wide;
   logic [POS_W-1:0]   pos_inc;
   logic [START_W-1:0] len17;
   logic [2:0]         kind;
   logic [2:0]         status;
   logic [POS_W-1:0]   plen;

   always_comb begin
      b = req.data_byte;
      first_in = (pos_ff == '0) ? b : first_ff;
      second_in = (pos_ff == 16'd1) ? b : second_ff;
      seq_in = (pos_ff == 16'd2 || pos_ff == 16'd3) ? {seq_ff[7:0], b} : seq_ff;
      ts_in = (pos_ff >= 16'd4 && pos_ff < 16'd8) ? {ts_ff[23:0], b} : ts_ff;
      src_in = (pos_ff >= 16'd8 && pos_ff < HDR_BYTES) ? {src_ff[23:0], b} : src_ff;

      cc = first_in[3:0];
      xbit = first_in[4];
      csrc_end = 7'd12 + {1'b0, cc, 2'b00};
      csrc_end16 = {9'b0, csrc_end};
      ext_data_start = csrc_end16 + WORD_BYTES;
      in_ext_hdr = xbit && (pos_ff >= csrc_end16) && (pos_ff < ext_data_start);

      extw_in = extw_ff;
      ps_wide = '0;
      if (pos_ff == '0) begin
         pstart_in = {10'b0, csrc_end} + {14'b0, xbit, 2'b00};
      end else begin
         pstart_in = pstart_ff;
      end
      // extension length word: high byte then low byte
      if (in_ext_hdr && pos_ff == csrc_end16 + 16'd2) begin
         extw_in = {b, 8'h00};
      end else if (in_ext_hdr && pos_ff == csrc_end16 + 16'd3) begin
         extw_in = extw_ff | {8'h00, b};
         ps_wide = {12'b0, csrc_end} + 19'd4 + {1'b0, extw_in, 2'b00};
         pstart_in = (ps_wide > {2'b00, START_MAX}) ? START_MAX : ps_wide[START_W-1:0];
      end

      if (pos_ff < HDR_BYTES) begin
         kind = KIND_FIXED;
      end else if (pos_ff < csrc_end16) begin
         kind = KIND_CSRC;
      end else if (in_ext_hdr) begin
         kind = KIND_EXT_HDR;
      end else if (xbit && {1'b0, pos_ff} < pstart_in) begin
         kind = (pos_ff - ext_data_start < cfg.ext_data_capacity) ? KIND_EXT_DATA
                                                                   : KIND_EXT_SKIP;
      end else begin
         kind = KIND_PAYLOAD;
      end

      // saturating increment doubles as the packet length on the last byte
      pos_inc = (pos_ff == MAX_PACKET_BYTES) ? pos_ff : pos_ff + 16'd1;
      len17 = {1'b0, pos_inc};

      plen = '0;
      if (pos_inc < HDR_BYTES) begin
         status = STATUS_TOO_SHORT;
      end else if (first_in[7:6] != HDR_VERSION) begin
         status = STATUS_BAD_VERSION;
      end else if (csrc_end16 > pos_inc) begin
         status = STATUS_CSRC_CUT;
      end else if (xbit && ext_data_start > pos_inc) begin
         status = STATUS_EXT_HDR_CUT;
      end else if (xbit && pstart_in > len17) begin
         status = STATUS_EXT_DATA_CUT;
      end else begin
         status = STATUS_OK;
         if (len17 > pstart_in) begin
            plen = pos_inc - pstart_in[POS_W-1:0];
            if (plen > cfg.payload_capacity) begin
               plen = '0;
            end
         end
      end

      pos_in = pos_inc;

      result = '0;
      result.byte_value = b;
      result.byte_kind = kind;
      if (req.last_byte) begin
         result.packet_done = 1'b1;
         result.status = status;
         result.marker = second_in[7];
         result.pt_value = second_in[6:0];
         result.sequence_value = seq_in;
         result.timestamp_value = ts_in;
         result.source_id = src_in;
         result.contributor_count = cc;
         result.has_extension = xbit;
         result.payload_bytes = plen;
      end
   end

   // packet state is cleared at the end of each packet
   always_ff @(posedge clock) begin
      if (reset || (accept && req.last_byte)) begin
         pos_ff <= '0;
         first_ff <= '0;
         second_ff <= '0;
         seq_ff <= '0;
         ts_ff <= '0;
         src_ff <= '0;
         extw_ff <= '0;
         pstart_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         first_ff <= first_in;
         second_ff <= second_in;
         seq_ff <= seq_in;
         ts_ff <= ts_in;
         src_ff <= src_in;
         extw_ff <= extw_in;
         pstart_ff <= pstart_in;
      end
   end

endmodule

[rtl/core/rtp_header_decoder.sv]
// RTP header decoder
// Request channel (req_valid, req_stall, req_data): one packet byte per
// request in wire order, last_byte set on the final byte of each packet.
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one response
// per request, in order, carrying the byte, its region tag and, on the last
// byte, the status and the decoded header fields.
// CSR port (csr_valid, csr_ready, csr_index, csr_wdata): index 0 sets the
// payload capacity, index 1 the kept extension data length. Always ready;
// write only between packets with no response outstanding.
// Each response is registered in the output stage; one request is taken every
// cycle while req_stall is low, set by the single byte-position compare and update per byte.
// Reset clears the byte position, all packet fields and both channel stages,
// and loads capacities 1024 and 64.
// When the receiver stalls, the response holds in the output register and one
// more request lands in a skid register; req_stall then rises and stays high
// until the skid entry has moved to the output.
module rtp_header_decoder
   import rtphd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wdata
);

   cfg_type cfg_ff;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   rsp_type result;
   logic    accept;
   logic    take;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept = req_valid && !skid_valid_ff;
   assign take = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   rtphd_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in = out_ff;
      skid_in = skid_ff;
      if (take && skid_valid_ff) begin
         out_in = skid_ff;
         skid_valid_in = 1'b0;
      end else if (take || !out_valid_ff) begin
         out_valid_in = accept;
         out_in = result;
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
         cfg_ff.payload_capacity <= PAYLOAD_CAPACITY_RESET;
         cfg_ff.ext_data_capacity <= EXT_DATA_CAPACITY_RESET;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_PAYLOAD_CAPACITY:  cfg_ff.payload_capacity <= csr_wdata;
               CSR_EXT_DATA_CAPACITY: cfg_ff.ext_data_capacity <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

endmodule

[rtl/core/rtphd_checker.sv]
module rtphd_checker
   import rtphd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // skid stage only fills behind a held response
   a_stall_implies_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no response held");

   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.packet_done |->
         rsp_data.status == STATUS_OK && rsp_data.payload_bytes == '0)
      else $error("summary fields set on a non-final byte");

   a_failed_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.packet_done && rsp_data.status != STATUS_OK |->
         rsp_data.payload_bytes == '0)
      else $error("payload length reported on a failed packet");

   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid && !req_stall)
      else $error("channel stages not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind rtp_header_decoder rtphd_checker u_rtphd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[sim/rtp_decode_checker.sv]
`timescale 1ns / 1ps

module rtp_decode_checker
   import rtphd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wdata,
   output int                     mismatch_count,
   output int                     outstanding
);

   logic [15:0] payload_cap;
   logic [15:0] ext_keep_cap;

   logic [15:0] byte_pos;
   logic [7:0]  hdr_byte0;
   logic [7:0]  hdr_byte1;
   logic [15:0] seq_acc;
   logic [31:0] ts_acc;
   logic [31:0] ssrc_acc;
   logic [15:0] ext_words;
   logic [16:0] payload_off;

   rsp_type decoded_q[$];
   int      mismatches;

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // tags one packet byte and, on the last byte, builds the packet summary
   function automatic rsp_type decode_byte(req_type r);
      rsp_type     o;
      logic [7:0]  b;
      logic [3:0]  cc;
      logic        xbit;
      logic [2:0]  kind;
      logic [2:0]  stat;
      int unsigned pos;
      int unsigned csrc_end;
      int unsigned ext_end;
      int unsigned span;
      int unsigned len;
      int unsigned plen;
      int unsigned hdr;
      int unsigned word;
      int unsigned pos_top;

      o = '0;
      b = r.data_byte;
      hdr = 32'(HDR_BYTES);
      word = 32'(WORD_BYTES);
      pos_top = 32'(MAX_PACKET_BYTES);
      if (byte_pos == '0) begin
         hdr_byte0 = '0;
         hdr_byte1 = '0;
         seq_acc = '0;
         ts_acc = '0;
         ssrc_acc = '0;
         ext_words = '0;
         payload_off = '0;
      end
      pos = 32'(byte_pos);

      if (pos == 0) begin
         hdr_byte0 = b;
         payload_off = 17'(hdr + word * 32'(b[3:0]) + (b[4] ? word : 32'd0));
      end else if (pos == 1) begin
         hdr_byte1 = b;
      end else if (pos < 4) begin
         seq_acc = {seq_acc[7:0], b};
      end else if (pos < 8) begin
         ts_acc = {ts_acc[23:0], b};
      end else if (pos < hdr) begin
         ssrc_acc = {ssrc_acc[23:0], b};
      end

      cc = hdr_byte0[3:0];
      xbit = hdr_byte0[4];
      csrc_end = hdr + word * 32'(cc);
      ext_end = csrc_end + word;

      if (pos < hdr) begin
         kind = KIND_FIXED;
      end else if (pos < csrc_end) begin
         kind = KIND_CSRC;
      end else if (xbit && pos < ext_end) begin
         kind = KIND_EXT_HDR;
         // extension length in words sits in the last two bytes of the ext header
         if (pos == csrc_end + 2) begin
            ext_words = {b, 8'h00};
         end else if (pos == csrc_end + 3) begin
            ext_words[7:0] = b;
            span = ext_end + word * 32'(ext_words);
            payload_off = (span > 32'(START_MAX)) ? START_MAX : span[16:0];
         end
      end else if (xbit && pos < 32'(payload_off)) begin
         kind = (pos - ext_end < 32'(ext_keep_cap)) ? KIND_EXT_DATA : KIND_EXT_SKIP;
      end else begin
         kind = KIND_PAYLOAD;
      end

      o.byte_value = b;
      o.byte_kind = kind;

      if (!r.last_byte) begin
         byte_pos = (pos < pos_top) ? 16'(pos + 1) : MAX_PACKET_BYTES;
         return o;
      end

      len = (pos < pos_top) ? pos + 1 : pos_top;
      plen = 0;
      if (len < hdr) begin
         stat = STATUS_TOO_SHORT;
      end else if (hdr_byte0[7:6] != HDR_VERSION) begin
         stat = STATUS_BAD_VERSION;
      end else if (csrc_end > len) begin
         stat = STATUS_CSRC_CUT;
      end else if (xbit && ext_end > len) begin
         stat = STATUS_EXT_HDR_CUT;
      end else if (xbit && 32'(payload_off) > len) begin
         stat = STATUS_EXT_DATA_CUT;
      end else begin
         stat = STATUS_OK;
         if (len > 32'(payload_off)) begin
            plen = len - 32'(payload_off);
            if (plen > 32'(payload_cap)) plen = 0;
         end
      end

      o.packet_done = 1'b1;
      o.status = stat;
      o.marker = hdr_byte1[7];
      o.pt_value = hdr_byte1[6:0];
      o.sequence_value = seq_acc;
      o.timestamp_value = ts_acc;
      o.source_id = ssrc_acc;
      o.contributor_count = cc;
      o.has_extension = xbit;
      o.payload_bytes = plen[15:0];
      byte_pos = '0;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         payload_cap = PAYLOAD_CAPACITY_RESET;
         ext_keep_cap = EXT_DATA_CAPACITY_RESET;
         byte_pos = '0;
         hdr_byte0 = '0;
         hdr_byte1 = '0;
         seq_acc = '0;
         ts_acc = '0;
         ssrc_acc = '0;
         ext_words = '0;
         payload_off = '0;
         decoded_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PAYLOAD_CAPACITY: payload_cap = csr_wdata;
               CSR_EXT_DATA_CAPACITY: ext_keep_cap = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            decoded_q.insert(decoded_q.size(), decode_byte(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               $error("response with no request pending: byte_value %0h", rsp_data.byte_value);
               mismatches++;
            end else begin
               want = decoded_q[0];
               decoded_q.delete(0);
               check_field("byte_value", 32'(want.byte_value), 32'(rsp_data.byte_value));
               check_field("byte_kind", 32'(want.byte_kind), 32'(rsp_data.byte_kind));
               check_field("packet_done", 32'(want.packet_done), 32'(rsp_data.packet_done));
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("marker", 32'(want.marker), 32'(rsp_data.marker));
               check_field("pt_value", 32'(want.pt_value), 32'(rsp_data.pt_value));
               check_field("sequence_value", 32'(want.sequence_value),
                           32'(rsp_data.sequence_value));
               check_field("timestamp_value", want.timestamp_value, rsp_data.timestamp_value);
               check_field("source_id", want.source_id, rsp_data.source_id);
               check_field("contributor_count", 32'(want.contributor_count),
                           32'(rsp_data.contributor_count));
               check_field("has_extension", 32'(want.has_extension),
                           32'(rsp_data.has_extension));
               check_field("payload_bytes", 32'(want.payload_bytes),
                           32'(rsp_data.payload_bytes));
            end
         end
      end
      mismatch_count <= mismatches;
      outstanding <= decoded_q.size();
   end

endmodule

[sim/tb_rtp_header_decoder.sv]
`timescale 1ns / 1ps

module tb_rtp_header_decoder
   import rtphd_pkg::*;
();

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PAYLOAD_CAPACITY;
   logic [15:0]            csr_wdata = '0;
   int                     mismatch_count;
   int                     outstanding;

   bit         tx_gaps;
   bit         rx_gaps;
   bit         tail_quiet;
   logic [7:0] pkt_bytes[$];
   int         pkt_count;
   int         bytes_sent;
   int         settings_used;

   rtp_header_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rtp_decode_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("== FAIL ==");
      $finish;
   end

   // receiver back-pressure in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (rx_gaps && $urandom_range(0, 6) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      if (tx_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, last_byte: last};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic add_byte(input logic [7:0] v);
      pkt_bytes.insert(pkt_bytes.size(), v);
   endtask

   task automatic send_packet(input bit pause_mid);
      int n;
      n = pkt_bytes.size();
      for (int i = 0; i < n; i++) begin
         if (pause_mid && i > 0 && i == n / 2) wait_drained();
         push_byte(pkt_bytes[i], i == n - 1);
      end
      pkt_count++;
      bytes_sent += n;
   endtask

   task automatic set_capacities(input logic [15:0] pay_cap, input logic [15:0] ext_cap);
      wait_drained();
      repeat (2) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_PAYLOAD_CAPACITY;
      csr_wdata <= pay_cap;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_EXT_DATA_CAPACITY;
      csr_wdata <= ext_cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // ext_fill is the number of extension data bytes actually appended
   task automatic build_rtp(input logic [1:0] ver, input logic [3:0] cc, input logic xbit,
                            input logic [15:0] ext_len, input int ext_fill, input int pay_len);
      pkt_bytes.delete();
      add_byte({ver, 1'($urandom_range(0, 1)), xbit, cc});
      repeat (11 + 4 * cc) add_byte(8'($urandom));
      if (xbit) begin
         add_byte(8'($urandom));
         add_byte(8'($urandom));
         add_byte(ext_len[15:8]);
         add_byte(ext_len[7:0]);
         repeat (ext_fill) add_byte(8'($urandom));
      end
      repeat (pay_len) add_byte(8'($urandom));
   endtask

   task automatic random_packet();
      int          pick;
      int          keep;
      int          pay_len;
      int          vsel;
      logic [1:0]  ver;
      logic [3:0]  cc;
      logic        xbit;
      logic [15:0] ext_len;

      pick = $urandom_range(0, 99);
      cc = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
      xbit = 1'($urandom_range(0, 1));
      ext_len = 16'($urandom_range(0, 4));
      pay_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      ver = HDR_VERSION;

      if (pick < 88) begin
         if (pick >= 66 && pick < 78) begin
            vsel = $urandom_range(0, 2);
            ver = (vsel == 2) ? 2'd3 : 2'(vsel);
         end
         if (pick >= 78) begin
            // long extension length, only a little of it ever arrives
            build_rtp(ver, cc, 1'b1, 16'($urandom), $urandom_range(0, 12), 0);
         end else begin
            build_rtp(ver, cc, xbit, ext_len, 4 * ext_len, pay_len);
         end
         if (pick >= 55 && pick < 66) begin
            keep = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
         end
      end else begin
         pkt_bytes.delete();
         repeat ($urandom_range(1, 20)) add_byte(8'($urandom));
      end
   endtask

   task automatic run_random(input int byte_goal);
      while (bytes_sent < byte_goal) begin
         tx_gaps = !tail_quiet && $urandom_range(0, 3) != 0;
         rx_gaps = !tail_quiet && $urandom_range(0, 3) != 0;
         random_packet();
         send_packet($urandom_range(0, 19) == 0);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;

      // single byte, header of all ones, minimal header with empty payload
      pkt_bytes.delete();
      add_byte(8'h00);
      send_packet(1'b0);
      pkt_bytes.delete();
      repeat (12) add_byte(8'hFF);
      send_packet(1'b0);
      pkt_bytes.delete();
      add_byte(8'h80);
      add_byte(8'h7F);
      repeat (10) add_byte(8'hFF);
      send_packet(1'b0);

      run_random(175);
      set_capacities(16'd1, 16'd0);
      run_random(320);
      set_capacities(16'hFFFF, 16'hFFFF);
      run_random(470);
      set_capacities(16'd0, 16'($urandom_range(0, 8)));
      run_random(600);
      set_capacities(16'($urandom_range(1, 32)), 16'($urandom_range(0, 12)));
      run_random(720);

      set_capacities(16'hFFFF, 16'd8);
      tail_quiet = 1'b1;
      run_random(850);

      wait_drained();
      repeat (4) @(posedge clock);
      if (outstanding != 0) $error("%0d responses never arrived", outstanding);
      $display("sent %0d packets (%0d bytes) under %0d capacity settings", pkt_count,
               bytes_sent, settings_used);
      $display("mix: well-formed, truncated, bad-version, long-extension and noise packets");
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
